@@ hw/rtl/ptsch_pkg.sv @@
// ----------------------------------------------------------------------------
// ptsch_pkg
// Shared types and constants for the priority task scheduler: item structs,
// status codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package ptsch_pkg;

    localparam int unsigned LEVELS   = 16;
    localparam int unsigned LVL_W    = $clog2(LEVELS);
    localparam int unsigned DEPTH    = 16;
    localparam int unsigned SLOT_W   = $clog2(DEPTH);
    localparam int unsigned FILL_W   = $clog2(DEPTH + 1);
    localparam int unsigned ADDR_W   = LVL_W + SLOT_W;
    localparam int unsigned ENTRIES  = LEVELS * DEPTH;
    localparam int unsigned ID_W     = 32;
    localparam int unsigned TAG_W    = 32;
    localparam int unsigned RUN_W    = 8;
    localparam int unsigned QCNT_W   = 9;
    localparam int unsigned PRIO_W   = 4;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [RUN_W-1:0] MAX_CONC_RESET = RUN_W'(1);

    typedef enum logic [2:0] {
        ST_STARTED  = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_FREED    = 3'd2,
        ST_REJECTED = 3'd3,
        ST_IDLE     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_READY,
        S_DECIDE,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic              op;
        logic [PRIO_W-1:0] priority_req;
        logic [TAG_W-1:0]  task_tag;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [ID_W-1:0]   task_id;
        logic [TAG_W-1:0]  task_tag_out;
        logic [RUN_W-1:0]  running_count;
        logic [QCNT_W-1:0] queued_count;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic decide;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_hold;
    } t_sts;

endpackage

@@ hw/rtl/priority_task_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// priority_task_scheduler_top
// Strict-priority task admission with one FIFO per priority level.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): submit or finish items,
// a transfer when valid is high and stall is low. Output channel
// (o_out_valid / i_out_stall / o_out_item): one result per input item, in order.
// Configuration: i_cfg_we writes i_cfg_data to the run limit; write only while
// no item is in flight.
// Flow: an accepted item is captured, decided into the result registers and
// then loaded into the output register. The decide step (level pointer
// read-modify-write and waiting store access) takes no new item; a new item
// is taken in the load cycle.
// Back-pressure: the output register holds a result while i_out_stall is high;
// the next item may then be captured and decided, but waits in its load step
// until the held result is transferred.
// Reset (synchronous, active low): run limit 1, counters, ids and level
// pointers cleared, no result pending. The waiting store needs no clearing.
// ----------------------------------------------------------------------------
module priority_task_scheduler_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ptsch_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ptsch_pkg::t_out_item o_out_item,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_data
);

    ptsch_pkg::t_cmd cmd;
    ptsch_pkg::t_sts sts;

    ptsch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ptsch_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

@@ hw/rtl/ptsch_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptsch_ctrl
// Controller: sequences each item through capture, decision and result load,
// and drives the input stall.
// ----------------------------------------------------------------------------
module ptsch_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ptsch_pkg::t_sts   i_sts,
    output ptsch_pkg::t_cmd   o_cmd
);

    ptsch_pkg::t_state r_state;
    ptsch_pkg::t_state n_state;
    logic              in_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptsch_pkg::S_READY;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ptsch_pkg::S_READY: begin
                if (i_in_valid) begin
                    n_state = ptsch_pkg::S_DECIDE;
                end
            end
            ptsch_pkg::S_DECIDE: begin
                n_state = ptsch_pkg::S_LOAD;
            end
            ptsch_pkg::S_LOAD: begin
                if (!i_sts.out_hold) begin
                    n_state = i_in_valid ? ptsch_pkg::S_DECIDE : ptsch_pkg::S_READY;
                end
            end
            default: begin
                n_state = ptsch_pkg::S_READY;
            end
        endcase
    end

    always_comb begin
        in_open      = 1'b0;
        o_cmd.decide = 1'b0;
        o_cmd.load   = 1'b0;
        case (r_state)
            ptsch_pkg::S_READY: begin
                in_open = 1'b1;
            end
            ptsch_pkg::S_DECIDE: begin
                o_cmd.decide = 1'b1;
            end
            ptsch_pkg::S_LOAD: begin
                in_open    = !i_sts.out_hold;
                o_cmd.load = !i_sts.out_hold;
            end
            default: begin
                in_open = 1'b0;
            end
        endcase
        o_in_stall   = !in_open;
        o_cmd.accept = i_in_valid && in_open;
    end

endmodule

@@ hw/rtl/ptsch_dp.sv @@
// ----------------------------------------------------------------------------
// ptsch_dp
// Datapath: run and wait counters, per-level FIFO pointers, waiting store
// memory, decision logic and the output register.
// ----------------------------------------------------------------------------
module ptsch_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptsch_pkg::t_cmd      i_cmd,
    output ptsch_pkg::t_sts      o_sts,
    input  ptsch_pkg::t_in_item  i_in_item,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ptsch_pkg::t_out_item o_out_item
);

    localparam int unsigned LEVELS = ptsch_pkg::LEVELS;
    localparam int unsigned LVL_W  = ptsch_pkg::LVL_W;
    localparam int unsigned SLOT_W = ptsch_pkg::SLOT_W;
    localparam int unsigned FILL_W = ptsch_pkg::FILL_W;
    localparam int unsigned ADDR_W = ptsch_pkg::ADDR_W;
    localparam int unsigned ID_W   = ptsch_pkg::ID_W;
    localparam int unsigned TAG_W  = ptsch_pkg::TAG_W;
    localparam int unsigned RUN_W  = ptsch_pkg::RUN_W;
    localparam int unsigned QCNT_W = ptsch_pkg::QCNT_W;

    logic                 r_op;
    logic [LVL_W-1:0]     r_prio;
    logic [TAG_W-1:0]     r_tag;
    logic [RUN_W-1:0]     r_max_conc;
    logic [ID_W-1:0]      r_last_id;
    logic [RUN_W-1:0]     r_running;
    logic [QCNT_W-1:0]    r_total;
    logic [SLOT_W-1:0]    r_head [LEVELS];
    logic [SLOT_W-1:0]    r_tail [LEVELS];
    logic [FILL_W-1:0]    r_fill [LEVELS];
    logic [ID_W+TAG_W-1:0] r_store [ptsch_pkg::ENTRIES];
    logic [ID_W+TAG_W-1:0] r_rd_data;
    logic [2:0]           r_res_status;
    logic [ID_W-1:0]      r_res_id;
    logic [TAG_W-1:0]     r_res_tag;
    logic                 r_res_mem;
    logic                 r_out_valid;
    ptsch_pkg::t_out_item r_out_item;

    logic [LEVELS-1:0]    nonempty;
    logic [LVL_W-1:0]     top_lvl;
    logic [LVL_W-1:0]     lvl;
    logic [ID_W-1:0]      next_id;
    logic [SLOT_W-1:0]    sel_head;
    logic [SLOT_W-1:0]    sel_tail;
    logic [FILL_W-1:0]    sel_fill;
    logic                 do_start;
    logic                 do_reject;
    logic                 do_queue;
    logic                 do_idle;
    logic                 do_pop;
    logic                 do_free;

    always_comb begin
        top_lvl = '0;
        for (int l = 0; l < LEVELS; l++) begin
            nonempty[l] = (r_fill[l] != '0);
            if (nonempty[l]) begin
                top_lvl = LVL_W'(l);
            end
        end
    end

    always_comb begin
        lvl       = (r_op == ptsch_pkg::OP_FINISH) ? top_lvl : r_prio;
        sel_head  = r_head[lvl];
        sel_tail  = r_tail[lvl];
        sel_fill  = r_fill[lvl];
        next_id   = r_last_id + ID_W'(1);
        do_start  = (r_op == ptsch_pkg::OP_SUBMIT) && (r_running < r_max_conc);
        do_reject = (r_op == ptsch_pkg::OP_SUBMIT) && !do_start
                    && (sel_fill == FILL_W'(ptsch_pkg::DEPTH));
        do_queue  = (r_op == ptsch_pkg::OP_SUBMIT) && !do_start && !do_reject;
        do_idle   = (r_op == ptsch_pkg::OP_FINISH) && (r_running == '0);
        do_pop    = (r_op == ptsch_pkg::OP_FINISH) && !do_idle && (nonempty != '0);
        do_free   = (r_op == ptsch_pkg::OP_FINISH) && !do_idle && (nonempty == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_in_item.op;
            r_prio <= LVL_W'(i_in_item.priority_req);
            r_tag  <= i_in_item.task_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_conc <= ptsch_pkg::MAX_CONC_RESET;
        end else if (i_cfg_we) begin
            r_max_conc <= RUN_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_id <= '0;
            r_running <= '0;
            r_total   <= '0;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
                r_fill[l] <= '0;
            end
        end else if (i_cmd.decide) begin
            if (r_op == ptsch_pkg::OP_SUBMIT) begin
                r_last_id <= next_id;
            end
            if (do_start) begin
                r_running <= r_running + RUN_W'(1);
            end
            if (do_free) begin
                r_running <= r_running - RUN_W'(1);
            end
            if (do_queue) begin
                r_tail[lvl] <= sel_tail + SLOT_W'(1);
                r_fill[lvl] <= sel_fill + FILL_W'(1);
                r_total     <= r_total + QCNT_W'(1);
            end
            if (do_pop) begin
                r_head[lvl] <= sel_head + SLOT_W'(1);
                r_fill[lvl] <= sel_fill - FILL_W'(1);
                r_total     <= r_total - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && do_queue) begin
            r_store[{lvl, sel_tail}] <= {next_id, r_tag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && do_pop) begin
            r_rd_data <= r_store[ADDR_W'({lvl, sel_head})];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_res_mem <= do_pop;
            r_res_id  <= (r_op == ptsch_pkg::OP_SUBMIT) ? next_id : '0;
            r_res_tag <= do_start ? r_tag : '0;
            if (do_start || do_pop) begin
                r_res_status <= ptsch_pkg::ST_STARTED;
            end else if (do_reject) begin
                r_res_status <= ptsch_pkg::ST_REJECTED;
            end else if (do_queue) begin
                r_res_status <= ptsch_pkg::ST_QUEUED;
            end else if (do_idle) begin
                r_res_status <= ptsch_pkg::ST_IDLE;
            end else begin
                r_res_status <= ptsch_pkg::ST_FREED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_item.status        <= r_res_status;
            r_out_item.task_id       <= r_res_mem ? r_rd_data[ID_W+TAG_W-1:TAG_W] : r_res_id;
            r_out_item.task_tag_out  <= r_res_mem ? r_rd_data[TAG_W-1:0] : r_res_tag;
            r_out_item.running_count <= r_running;
            r_out_item.queued_count  <= r_total;
        end
    end

    assign o_sts.out_hold = r_out_valid && i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out_item;

endmodule

@@ verif/priority_task_scheduler_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_scheduler_top_tb
// Self-checking bench for the strict-priority task scheduler. A directed
// opener covers idle finishes, start, queueing in level order, freeing a
// slot, a zero run limit and a full level. Random phases follow, each with
// its own run limit and idling pattern. A scoreboard keeps its own run count,
// per-level waiting FIFOs and id counter, predicts each result, and compares
// every output transfer field by field.
// ----------------------------------------------------------------------------
module priority_task_scheduler_top_tb;

    localparam int SQUEEZE_LEN = 300;

    localparam int unsigned LEVELS  = ptsch_pkg::LEVELS;
    localparam int unsigned DEPTH   = ptsch_pkg::DEPTH;
    localparam int unsigned ENTRIES = ptsch_pkg::ENTRIES;
    localparam int unsigned LVL_W   = ptsch_pkg::LVL_W;
    localparam int unsigned SLOT_W  = ptsch_pkg::SLOT_W;
    localparam int unsigned FILL_W  = ptsch_pkg::FILL_W;
    localparam int unsigned ID_W    = ptsch_pkg::ID_W;
    localparam int unsigned TAG_W   = ptsch_pkg::TAG_W;
    localparam int unsigned RUN_W   = ptsch_pkg::RUN_W;
    localparam int unsigned QCNT_W  = ptsch_pkg::QCNT_W;
    localparam int unsigned PRIO_W  = ptsch_pkg::PRIO_W;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    ptsch_pkg::t_in_item  i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    ptsch_pkg::t_out_item o_out_item;
    logic                 i_cfg_we    = 1'b0;
    logic [7:0]           i_cfg_data  = '0;

    priority_task_scheduler_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // scoreboard state
    logic [RUN_W-1:0]   run_limit = ptsch_pkg::MAX_CONC_RESET;
    logic [RUN_W-1:0]   run_count = '0;
    logic [ID_W-1:0]    id_counter = '0;
    logic [QCNT_W-1:0]  parked_total = '0;
    logic [63:0]        parked [ENTRIES];
    logic [SLOT_W-1:0]  lvl_head [LEVELS];
    logic [SLOT_W-1:0]  lvl_tail [LEVELS];
    logic [FILL_W-1:0]  lvl_fill [LEVELS];

    ptsch_pkg::t_in_item  task_requests [$];
    ptsch_pkg::t_out_item sched_outcomes [$];
    ptsch_pkg::t_out_item outcome_due;

    int unsigned send_gap_pct = 0;
    int unsigned stall_pct    = 0;
    bit          squeeze_on   = 1'b0;
    bit          squeeze_done = 1'b0;
    int          squeeze_cycles = 0;
    int          fail_count   = 0;

    function automatic ptsch_pkg::t_out_item schedule_item(ptsch_pkg::t_in_item req);
        ptsch_pkg::t_out_item res;
        logic [LVL_W-1:0] lvl;
        int top;
        int addr;
        res = '0;
        if (req.op == ptsch_pkg::OP_SUBMIT) begin
            id_counter = id_counter + 1'b1;
            lvl = req.priority_req;
            res.task_id = id_counter;
            if (run_count < run_limit) begin
                run_count = run_count + 1'b1;
                res.status = ptsch_pkg::ST_STARTED;
                res.task_tag_out = req.task_tag;
            end else if (lvl_fill[lvl] >= DEPTH) begin
                res.status = ptsch_pkg::ST_REJECTED;
            end else begin
                addr = int'(lvl) * DEPTH + int'(lvl_tail[lvl]);
                parked[addr] = {id_counter, req.task_tag};
                lvl_tail[lvl] = (lvl_tail[lvl] == DEPTH - 1) ? '0 : lvl_tail[lvl] + 1'b1;
                lvl_fill[lvl] = lvl_fill[lvl] + 1'b1;
                parked_total = parked_total + 1'b1;
                res.status = ptsch_pkg::ST_QUEUED;
            end
        end else if (run_count == 0) begin
            res.status = ptsch_pkg::ST_IDLE;
        end else begin
            top = -1;
            for (int l = LEVELS - 1; l >= 0 && top < 0; l--) begin
                if (lvl_fill[l] != 0) begin
                    top = l;
                end
            end
            if (top >= 0) begin
                addr = top * DEPTH + int'(lvl_head[top]);
                {res.task_id, res.task_tag_out} = parked[addr];
                lvl_head[top] = (lvl_head[top] == DEPTH - 1) ? '0 : lvl_head[top] + 1'b1;
                lvl_fill[top] = lvl_fill[top] - 1'b1;
                parked_total = parked_total - 1'b1;
                res.status = ptsch_pkg::ST_STARTED;
            end else begin
                run_count = run_count - 1'b1;
                res.status = ptsch_pkg::ST_FREED;
            end
        end
        res.running_count = run_count;
        res.queued_count = parked_total;
        return res;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // driver: offer pending requests, predict on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                sched_outcomes = {sched_outcomes, schedule_item(i_in_item)};
            end
            if (!i_in_valid || !o_in_stall) begin
                if (task_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= task_requests[0];
                    task_requests.delete(0);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (squeeze_on && !squeeze_done) begin
            i_out_stall <= 1'b1;
            squeeze_cycles++;
            if (squeeze_cycles >= SQUEEZE_LEN) begin
                squeeze_done = 1'b1;
            end
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sched_outcomes.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual %p", $time, o_out_item);
                fail_count++;
            end else begin
                outcome_due = sched_outcomes[0];
                sched_outcomes.delete(0);
                compare_field("status", 32'(outcome_due.status), 32'(o_out_item.status));
                compare_field("task_id", outcome_due.task_id, o_out_item.task_id);
                compare_field("task_tag_out", outcome_due.task_tag_out, o_out_item.task_tag_out);
                compare_field("running_count", 32'(outcome_due.running_count),
                              32'(o_out_item.running_count));
                compare_field("queued_count", 32'(outcome_due.queued_count),
                              32'(o_out_item.queued_count));
            end
        end
    end

    task automatic push_request(logic op, logic [PRIO_W-1:0] prio, logic [TAG_W-1:0] tag);
        ptsch_pkg::t_in_item req;
        req.op = op;
        req.priority_req = prio;
        req.task_tag = tag;
        task_requests = {task_requests, req};
    endtask

    task automatic settle();
        do @(posedge i_clk);
        while (task_requests.size() != 0 || i_in_valid || sched_outcomes.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_run_limit(logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        run_limit = value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // bursts with a submit-heavy, balanced or finish-heavy mix, some on few levels
    task automatic queue_random_requests(int count);
        int burst;
        int submit_pct;
        bit narrow;
        logic [PRIO_W-1:0] base;
        while (count > 0) begin
            burst = $urandom_range(40, 1);
            case ($urandom_range(2))
                0: submit_pct = 85;
                1: submit_pct = 50;
                default: submit_pct = 15;
            endcase
            narrow = 1'($urandom_range(1));
            base = PRIO_W'($urandom_range(LEVELS - 1));
            for (int k = 0; k < burst && count > 0; k++) begin
                push_request(($urandom_range(99) < submit_pct) ? ptsch_pkg::OP_SUBMIT
                                                               : ptsch_pkg::OP_FINISH,
                             narrow ? (base ^ PRIO_W'($urandom_range(1)))
                                    : PRIO_W'($urandom_range(15)),
                             $urandom());
                count--;
            end
        end
    endtask

    task automatic run_phase(logic [7:0] limit, int unsigned gap, int unsigned stall,
                             int count, bit squeeze);
        set_run_limit(limit);
        send_gap_pct = gap;
        stall_pct = stall;
        squeeze_on = squeeze;
        queue_random_requests(count);
        settle();
    endtask

    initial begin
        for (int l = 0; l < LEVELS; l++) begin
            lvl_head[l] = '0;
            lvl_tail[l] = '0;
            lvl_fill[l] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset limit of one: idle finish, start, ordered queueing, free
        push_request(ptsch_pkg::OP_FINISH, 4'h0, 32'h0000_0000);
        push_request(ptsch_pkg::OP_SUBMIT, 4'h0, 32'h0000_0000);
        push_request(ptsch_pkg::OP_SUBMIT, 4'hf, 32'hffff_ffff);
        push_request(ptsch_pkg::OP_SUBMIT, 4'h0, 32'ha5a5_a5a5);
        push_request(ptsch_pkg::OP_FINISH, 4'hf, 32'hffff_ffff);
        push_request(ptsch_pkg::OP_FINISH, 4'h0, 32'h5a5a_5a5a);
        push_request(ptsch_pkg::OP_FINISH, 4'h0, 32'h0000_0000);
        push_request(ptsch_pkg::OP_FINISH, 4'h0, 32'h0000_0000);
        settle();

        // zero limit: fill one level past its depth, then finish while idle
        set_run_limit(8'd0);
        for (int k = 0; k <= DEPTH; k++) begin
            push_request(ptsch_pkg::OP_SUBMIT, 4'h9, $urandom());
        end
        push_request(ptsch_pkg::OP_FINISH, 4'h9, 32'h0);
        settle();

        run_phase(8'd255, 0, 0, 150, 1'b0);
        run_phase(8'd4, 46, 0, 150, 1'b0);
        run_phase(8'd1, 0, 46, 150, 1'b0);
        run_phase(8'd16, 14, 14, 150, 1'b0);
        run_phase(8'd2, 0, 0, 150, 1'b1);
        run_phase(8'd7, 14, 14, 125, 1'b0);

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("priority_task_scheduler_top verification clean");
        end else begin
            $display("priority_task_scheduler_top verification failed");
        end
        $finish;
    end

    initial begin
        #400_000;
        $display("priority_task_scheduler_top verification failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ptsch_pkg.sv
hw/rtl/ptsch_ctrl.sv
hw/rtl/ptsch_dp.sv
hw/rtl/priority_task_scheduler_top.sv
verif/priority_task_scheduler_top_tb.sv
